// ===== hw/rtl/slit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package slit_pkg;

  localparam int DATA_W = 32;
  localparam int CAPACITY_DEF = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TRIM = 2'd1;
  localparam logic [1:0] OP_DUMP = 2'd2;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Commands broadcast to the row of cells.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_SHL = 2'd2;
  localparam logic [1:0] CMD_ROT = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [DATA_W-1:0] value;
  } slit_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/slit_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slit_cell #(
  parameter int IDX = 0,
  parameter int CNT_W = 5
) (
  input  wire                                 clk,
  input  wire slit_pkg::slit_ctl_t            ctl,
  input  wire [CNT_W-1:0]                     count,
  input  wire logic signed [slit_pkg::DATA_W-1:0] prev_entry,
  input  wire                                 prev_right,
  input  wire logic signed [slit_pkg::DATA_W-1:0] next_entry,
  input  wire logic signed [slit_pkg::DATA_W-1:0] head_entry,
  output logic signed [slit_pkg::DATA_W-1:0]  entry,
  output logic                                goes_right
);
  import slit_pkg::*;

  localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS_P1 = CNT_W'(IDX + 1);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic occupied;

  assign occupied = POS < count;
  // An occupied entry smaller than the new value stays where it is.
  assign goes_right = occupied && (entry_r < ctl.value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (!goes_right) begin
          if (IDX == 0 || prev_right) begin
            entry_nxt = ctl.value;
          end else begin
            entry_nxt = prev_entry;
          end
        end
      end
      CMD_SHL: begin
        if (IDX != 0) begin
          entry_nxt = next_entry;
        end
      end
      CMD_ROT: begin
        // The last occupied cell takes the head entry, which wraps around to the tail.
        if (POS_P1 == count) begin
          entry_nxt = head_entry;
        end else begin
          entry_nxt = next_entry;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_list_insert_trim.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   tuser opcode, tdata value
// out_     master     out_tvalid/out_tready tuser status, tdata data, tlast last
//
// On an insert the row of cells sorts the value into place at once.
// A trim of n > 2 entries shifts the row by one per cycle while the output is not stalled.
// A dump of n entries gives n results; the row rotates once per result.
// Reset clears the entry count and the control; the entries themselves are not cleared.
// A stalled output holds the sequencer; a new transfer is taken only when idle.
module sorted_list_insert_trim #(
  parameter int CAPACITY = slit_pkg::CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,   // [31:0] value
  input  wire [1:0]  in_tuser,   // [1:0] opcode
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [31:0] out_tdata, // [31:0] data
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);
  import slit_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TRIM = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r;
  logic [1:0] out_status_r;
  logic out_last_r;

  logic out_free;
  logic accept;
  logic emit;
  logic [1:0] emit_status;
  logic signed [DATA_W-1:0] emit_data;
  logic emit_last;
  slit_ctl_t ctl;

  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic goes_right [CAPACITY];

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    emit = 1'b0;
    emit_status = STAT_OK;
    emit_data = '0;
    emit_last = 1'b1;
    ctl.cmd = CMD_NONE;
    ctl.value = $signed(in_tdata);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            OP_INSERT: begin
              emit = 1'b1;
              if (count_r == CNT_CAP) begin
                emit_status = STAT_FULL;
              end else begin
                ctl.cmd = CMD_INSERT;
                count_nxt = count_r + CNT_ONE;
              end
            end
            OP_TRIM: begin
              if (count_r == '0) begin
                emit = 1'b1;
                emit_status = STAT_EMPTY;
              end else if (count_r <= CNT_TWO) begin
                emit = 1'b1;
              end else begin
                state_nxt = S_TRIM;
              end
            end
            OP_DUMP: begin
              if (count_r == '0) begin
                emit = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                state_nxt = S_DUMP;
                idx_nxt = '0;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_TRIM: begin
        // Each step pulls the tail one cell toward the head; cell 0 stays.
        if (out_free) begin
          ctl.cmd = CMD_SHL;
          count_nxt = count_r - CNT_ONE;
          if (count_r == CNT_THREE) begin
            emit = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        // The head is emitted and the row rotates, so n steps restore it.
        if (out_free) begin
          ctl.cmd = CMD_ROT;
          emit = 1'b1;
          emit_data = entry[0];
          emit_last = (idx_r + CNT_ONE) == count_r;
          idx_nxt = idx_r + CNT_ONE;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_e;
    logic signed [DATA_W-1:0] next_e;
    logic prev_r;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_r = 1'b0;
    end else begin : g_body
      assign prev_e = entry[i-1];
      assign prev_r = goes_right[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry[i+1];
    end
    slit_cell #(
      .IDX(i),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .count(count_r),
      .prev_entry(prev_e),
      .prev_right(prev_r),
      .next_entry(next_e),
      .head_entry(entry[0]),
      .entry(entry[i]),
      .goes_right(goes_right[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_data;
      out_status_r <= emit_status;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_status_r;
  assign out_tlast = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_CAP)
    else $error("entry count exceeds capacity");

  a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (idx_r < count_r))
    else $error("dump index ran past the stored entries");

  a_trim_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRIM) |-> (count_r > CNT_TWO))
    else $error("trim sequence active with two or fewer entries");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |-> out_last_r)
    else $error("error result not marked last");

endmodule
`default_nettype wire

// ===== tb/tb_sorted_list_insert_trim.sv =====
`timescale 1ns / 1ps
module tb_sorted_list_insert_trim;
  import slit_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NDIR = 22;
  localparam int RANDOM_ITEMS = 185;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic [7:0]  reps;
    logic        typed;
    logic [1:0]  t_status;
    logic [31:0] t_data;
    logic        t_last;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic in_tready;
  logic out_tvalid;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  sorted_list_insert_trim dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [31:0] value
    .in_tuser  (in_tuser),   // [1:0] opcode
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [31:0] data
    .out_tuser (out_tuser),  // [1:0] status
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // Shadow copy of the sorted store.
  logic signed [31:0] sorted_vals [CAP];
  int sorted_count = 0;

  result_t pending_results [$];
  result_t step_results [$];
  int errors = 0;
  int hold_requests = 0;
  stim_row_t directed [0:NDIR-1];

  task automatic predict_op(input logic [1:0] op, input logic signed [31:0] v);
    int pos;
    int i;
    step_results.delete();
    case (op)
      OP_INSERT: begin
        if (sorted_count >= CAP) begin
          step_results.push_back('{STAT_FULL, 32'd0, 1'b1});
        end else begin
          pos = 0;
          while (pos < sorted_count && sorted_vals[pos] < v) pos++;
          for (i = sorted_count; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[pos] = v;
          sorted_count++;
          step_results.push_back('{STAT_OK, 32'd0, 1'b1});
        end
      end
      OP_TRIM: begin
        if (sorted_count == 0) begin
          step_results.push_back('{STAT_EMPTY, 32'd0, 1'b1});
        end else begin
          if (sorted_count > 2) begin
            sorted_vals[1] = sorted_vals[sorted_count-1];
            sorted_count = 2;
          end
          step_results.push_back('{STAT_OK, 32'd0, 1'b1});
        end
      end
      OP_DUMP: begin
        if (sorted_count == 0) begin
          step_results.push_back('{STAT_EMPTY, 32'd0, 1'b1});
        end else begin
          for (i = 0; i < sorted_count; i++)
            step_results.push_back('{STAT_OK, sorted_vals[i], i == sorted_count - 1});
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and hold it until the transfer; typed rows replace the prediction.
  task automatic send_item(input logic [1:0] op, input logic [31:0] v,
                           input bit typed, input result_t typed_res);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_op(op, v);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return $signed($urandom_range(0, 16)) - 8;
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    if (sorted_count > 0) return sorted_vals[$urandom_range(0, sorted_count - 1)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_op(input bit fill_phase);
    int r;
    r = $urandom_range(0, 99);
    if (fill_phase) begin
      if (r < 80) return OP_INSERT;
      if (r < 85) return OP_TRIM;
      if (r < 97) return OP_DUMP;
      return OP_UNUSED;
    end
    if (r < 50) return OP_INSERT;
    if (r < 65) return OP_TRIM;
    if (r < 95) return OP_DUMP;
    return OP_UNUSED;
  endfunction

  // Receiver: random short stalls, steady stretches, and a long hold on request.
  initial begin
    int hold_left;
    int stall_left;
    int steady_left;
    int holds_served;
    int r;
    logic rdy;
    hold_left = 0;
    stall_left = 0;
    steady_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        rdy = 1'b1;
        steady_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          steady_left = $urandom_range(20, 80);
          rdy = 1'b1;
        end else if (r < 35) begin
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
      out_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status=%0d data=%h last=%0b",
                   out_tuser, out_tdata, out_tlast);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status || out_tdata !== want.data
            || out_tlast !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected status=%0d data=%h last=%0b,",
                     want.status, want.data, want.last,
                     " got status=%0d data=%h last=%0b",
                     out_tuser, out_tdata, out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int items;
    int k;
    bit fill_phase;
    logic [1:0] op;
    directed = '{
      '{OP_TRIM,   32'd0,         8'd1,  1'b1, STAT_EMPTY, 32'd0, 1'b1},
      '{OP_DUMP,   32'd0,         8'd1,  1'b1, STAT_EMPTY, 32'd0, 1'b1},
      '{OP_UNUSED, 32'h1234_5678, 8'd1,  1'b0, STAT_OK,    32'd0, 1'b0},
      '{OP_INSERT, 32'd0,         8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_TRIM,   32'd0,         8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_DUMP,   32'd0,         8'd1,  1'b0, STAT_OK,    32'd0, 1'b0},
      '{OP_INSERT, 32'h7fff_ffff, 8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_TRIM,   32'hffff_ffff, 8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_INSERT, 32'h8000_0000, 8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_INSERT, 32'hffff_ffff, 8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_INSERT, 32'd5,         8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_INSERT, 32'd5,         8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_INSERT, 32'h8000_0000, 8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_DUMP,   32'd0,         8'd1,  1'b0, STAT_OK,    32'd0, 1'b0},
      '{OP_TRIM,   32'd0,         8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_DUMP,   32'hffff_ffff, 8'd1,  1'b0, STAT_OK,    32'd0, 1'b0},
      '{OP_INSERT, 32'd100,       8'd14, 1'b0, STAT_OK,    32'd0, 1'b0},
      '{OP_INSERT, 32'd42,        8'd1,  1'b1, STAT_FULL,  32'd0, 1'b1},
      '{OP_DUMP,   32'd0,         8'd1,  1'b0, STAT_OK,    32'd0, 1'b0},
      '{OP_TRIM,   32'd0,         8'd1,  1'b1, STAT_OK,    32'd0, 1'b1},
      '{OP_DUMP,   32'd0,         8'd1,  1'b0, STAT_OK,    32'd0, 1'b0},
      '{OP_UNUSED, 32'd0,         8'd1,  1'b0, STAT_OK,    32'd0, 1'b0}
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Repeated rows step the value down so each insert lands in front of the last.
    for (int i = 0; i < NDIR; i++) begin
      for (k = 0; k < directed[i].reps; k++)
        send_item(directed[i].op, directed[i].value - 32'(k * 7), directed[i].typed,
                  '{directed[i].t_status, directed[i].t_data, directed[i].t_last});
    end
    drain_results();

    items = 0;
    fill_phase = 1'b1;
    while (items < RANDOM_ITEMS) begin
      if (items % 40 == 39) fill_phase = ~fill_phase;
      // Long receiver hold while items keep coming, then a full drain later on.
      if (items == 60) hold_requests++;
      if (items == 130) drain_results();
      op = pick_op(fill_phase);
      send_item(op, (op == OP_INSERT) ? pick_value() : 32'($urandom), 1'b0, '0);
      if (op != OP_UNUSED) items++;
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
